// File: rtl/range_edge_detect_3x3_core_macros.svh
// assertion macros for the edge detector rtl
// no dependencies; files that check their own logic include this header
`ifndef RANGE_EDGE_DETECT_3X3_CORE_MACROS_SVH
`define RANGE_EDGE_DETECT_3X3_CORE_MACROS_SVH

`ifndef SYNTHESIS
// expr holds at every clock edge out of reset
`define RED3_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
        else $error(msg);
// ante at one edge implies cons at the next
`define RED3_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RED3_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg)
`define RED3_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// File: rtl/red3_pkg.sv
// shared types and constants of the 3x3 range edge detector
// no dependencies; used by every other rtl file but the assertion macro header
package red3_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 11;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd32;
    localparam logic [CFG_W-1:0] WIDTH_RST     = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST    = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_idx_t;

    // tags of one request that ride along to the result
    typedef struct packed {
        logic               center_valid;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic               frame_end;
    } ctr_t;

endpackage

// File: rtl/red3_ifs.sv
// valid/ready channel interfaces for pixel requests and edge results
// depends on red3_pkg for field widths
interface red3_pix_if;
    logic                        valid;
    logic                        ready;
    logic [red3_pkg::PIX_W-1:0]  pixel_in;
    logic                        frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface red3_res_if;
    logic                          valid;
    logic                          ready;
    logic [red3_pkg::PIX_W-1:0]    edge_pixel;
    logic                          center_valid;
    logic [red3_pkg::COORD_W-1:0]  center_row;
    logic [red3_pkg::COORD_W-1:0]  center_col;
    logic                          frame_end;

    modport source (output valid, output edge_pixel, output center_valid,
                    output center_row, output center_col, output frame_end,
                    input ready);
    modport sink   (input valid, input edge_pixel, input center_valid,
                    input center_row, input center_col, input frame_end,
                    output ready);
endinterface

// File: rtl/red3_fifo.sv
// short request queue between the front (counters) and back (window) parts
// depends on red3_pkg and the assertion macro header
`include "range_edge_detect_3x3_core_macros.svh"

module red3_fifo #(
    parameter int DW    = 32,
    parameter int DEPTH = red3_pkg::FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    `RED3_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count past depth")
    `RED3_ASSERT_NEXT(a_fill, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CW'(1), "queue fill lost")
    `RED3_ASSERT_NEXT(a_drain, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CW'(1), "queue drain lost")

endmodule

// File: rtl/red3_front.sv
// front part: takes pixel requests, tracks row/column and tags each request
// depends on red3_pkg and red3_ifs; pushes into red3_fifo
module red3_front #(
    parameter int MAX_WIDTH  = red3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = red3_pkg::MAX_HEIGHT_DEF,
    parameter int AW         = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    red3_pix_if.sink                    pixels,
    input  logic [red3_pkg::CFG_W-1:0]  image_width,
    input  logic [red3_pkg::CFG_W-1:0]  image_height,
    input  logic                        q_full,
    output logic                        q_push,
    output logic [red3_pkg::PIX_W-1:0]  q_px,
    output logic [AW-1:0]               q_col,
    output red3_pkg::ctr_t              q_ctr
);

    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SZW0 = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                          $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int SZW  = (SZW0 > red3_pkg::CFG_W) ? SZW0 : red3_pkg::CFG_W;

    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [SZW-1:0] w_eff, h_eff;
    logic [SZW-1:0] col_s, row_s, col_a, row_a;
    logic [SZW-1:0] col_inc, row_inc;
    logic [AW-1:0]  col_cur;
    logic [RW-1:0]  row_cur;
    logic [RW-1:0]  row_m1;
    logic [AW-1:0]  col_m1;
    logic           inner;

    assign pixels.ready = !q_full;
    assign q_push       = pixels.valid && !q_full;

    always_comb
    begin
        // clamp the frame size to 3..max
        if (SZW'(image_width) < SZW'(3))
            w_eff = SZW'(3);
        else if (SZW'(image_width) > SZW'(MAX_WIDTH))
            w_eff = SZW'(MAX_WIDTH);
        else
            w_eff = SZW'(image_width);
        if (SZW'(image_height) < SZW'(3))
            h_eff = SZW'(3);
        else if (SZW'(image_height) > SZW'(MAX_HEIGHT))
            h_eff = SZW'(MAX_HEIGHT);
        else
            h_eff = SZW'(image_height);
    end

    always_comb
    begin
        col_s = pixels.frame_start ? '0 : SZW'(col_reg);
        row_s = pixels.frame_start ? '0 : SZW'(row_reg);
        // a counter left past a shrunk size wraps
        if (col_s >= w_eff)
        begin
            col_a = '0;
            row_a = row_s + SZW'(1);
        end
        else
        begin
            col_a = col_s;
            row_a = row_s;
        end
        if (row_a >= h_eff)
        begin
            row_a = '0;
        end
        col_cur = col_a[AW-1:0];
        row_cur = row_a[RW-1:0];
        row_m1  = row_cur - RW'(1);
        col_m1  = col_cur - AW'(1);
        inner   = (row_a >= SZW'(2)) && (col_a >= SZW'(2));

        q_px                = pixels.pixel_in;
        q_col               = col_cur;
        q_ctr.center_valid  = inner;
        q_ctr.center_row    = inner ? red3_pkg::COORD_W'(row_m1) : '0;
        q_ctr.center_col    = inner ? red3_pkg::COORD_W'(col_m1) : '0;
        q_ctr.frame_end     = (row_a == h_eff - SZW'(1)) && (col_a == w_eff - SZW'(1));

        col_inc = col_a + SZW'(1);
        row_inc = row_a + SZW'(1);
        if (col_inc >= w_eff)
        begin
            col_inc = '0;
            if (row_inc >= h_eff)
                row_inc = '0;
        end
        else
        begin
            row_inc = row_a;
        end
        col_next = col_inc[AW-1:0];
        row_next = row_inc[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (q_push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: rtl/red3_back.sv
// back part: line store read-modify-write, 3x3 window, max/min and threshold
// depends on red3_pkg and red3_ifs; pops from red3_fifo
module red3_back #(
    parameter int MAX_WIDTH = red3_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [red3_pkg::PIX_W-1:0]  edge_threshold,
    input  logic                        q_empty,
    input  logic [red3_pkg::PIX_W-1:0]  q_px,
    input  logic [AW-1:0]               q_col,
    input  red3_pkg::ctr_t              q_ctr,
    output logic                        q_pop,
    red3_res_if.source                  results
);

    localparam int PW = red3_pkg::PIX_W;

    // upper row in the high byte, middle row in the low byte
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] mem_q_reg;
    logic [2*PW-1:0] byp_data_reg;
    logic            byp_reg;
    logic [2*PW-1:0] col_data;
    logic [2*PW-1:0] wr_data;

    logic            adv;

    logic            s1_valid_reg;
    logic [AW-1:0]   s1_col_reg;
    logic [PW-1:0]   s1_px_reg;
    red3_pkg::ctr_t  s1_ctr_reg;

    logic [PW-1:0]   win_reg [9];
    logic            s2_valid_reg;
    red3_pkg::ctr_t  s2_ctr_reg;

    logic [PW-1:0]   win_max, win_min;
    logic            s3_valid_reg;
    red3_pkg::ctr_t  s3_ctr_reg;
    logic [PW-1:0]   s3_max_reg, s3_min_reg;
    logic [PW-1:0]   range;

    logic            out_valid_reg;
    logic [PW-1:0]   out_edge_reg;
    red3_pkg::ctr_t  out_ctr_reg;

    // whole back pipeline moves together whenever the output can take a slot
    assign adv      = !out_valid_reg || results.ready;
    assign q_pop    = adv && !q_empty;
    assign col_data = byp_reg ? byp_data_reg : mem_q_reg;
    assign wr_data  = {col_data[PW-1:0], s1_px_reg};

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
        if (q_pop)
        begin
            mem_q_reg    <= line_mem[q_col];
            // same column written this cycle: take the new data
            byp_reg      <= s1_valid_reg && (q_col == s1_col_reg);
            byp_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        win_max = win_reg[0];
        win_min = win_reg[0];
        for (int i = 1; i < 9; i++)
        begin
            if (win_reg[i] > win_max)
                win_max = win_reg[i];
            if (win_reg[i] < win_min)
                win_min = win_reg[i];
        end
        range = s3_max_reg - s3_min_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= col_data[2*PW-1:PW];
                win_reg[5] <= col_data[PW-1:0];
                win_reg[8] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (q_pop)
            begin
                s1_col_reg <= q_col;
                s1_px_reg  <= q_px;
                s1_ctr_reg <= q_ctr;
            end
            s2_ctr_reg   <= s1_ctr_reg;
            s3_ctr_reg   <= s2_ctr_reg;
            s3_max_reg   <= win_max;
            s3_min_reg   <= win_min;
            out_ctr_reg  <= s3_ctr_reg;
            out_edge_reg <= (s3_ctr_reg.center_valid && (range > edge_threshold)) ?
                            red3_pkg::EDGE_ON : red3_pkg::EDGE_OFF;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.edge_pixel   = out_edge_reg;
    assign results.center_valid = out_ctr_reg.center_valid;
    assign results.center_row   = out_ctr_reg.center_row;
    assign results.center_col   = out_ctr_reg.center_col;
    assign results.frame_end    = out_ctr_reg.frame_end;

endmodule

// File: rtl/range_edge_detect_3x3_core.sv
// Streaming 3x3 morphological-gradient edge detector. Pixels are taken one per clock in
// raster order while the request queue is not full; each request yields one result on the
// result channel, passing the queue, the s1, window, max/min and output registers. The sustained
// rate of one pixel per clock, when the output is not stalled, is set by the line store, a single
// MAX_WIDTH x 16 memory holding the two previous rows, which does one read and one write per
// pixel. Line store contents are undefined after reset (no clearing pass); they only reach results
// whose center_valid is 0. The user must write configuration only while idle; it is not enforced.
// depends on red3_pkg, red3_ifs, red3_fifo, red3_front and red3_back
module range_edge_detect_3x3_core #(
    parameter int MAX_WIDTH  = red3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = red3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    red3_pix_if.sink                        pixels,
    red3_res_if.source                      results,
    input  logic                            cfg_wen,
    input  logic [red3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [red3_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = $bits(red3_pkg::ctr_t) + red3_pkg::PIX_W + AW;

    logic [red3_pkg::PIX_W-1:0] threshold_reg;
    logic [red3_pkg::CFG_W-1:0] width_reg;
    logic [red3_pkg::CFG_W-1:0] height_reg;

    logic                       f_push;
    logic [red3_pkg::PIX_W-1:0] f_px;
    logic [AW-1:0]              f_col;
    red3_pkg::ctr_t             f_ctr;

    logic                       q_full, q_empty, q_pop;
    logic [DW-1:0]              q_dout;
    logic [red3_pkg::PIX_W-1:0] b_px;
    logic [AW-1:0]              b_col;
    red3_pkg::ctr_t             b_ctr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= red3_pkg::THRESHOLD_RST;
            width_reg     <= red3_pkg::WIDTH_RST;
            height_reg    <= red3_pkg::HEIGHT_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                red3_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[red3_pkg::PIX_W-1:0];
                red3_pkg::CFG_WIDTH:     width_reg     <= cfg_data;
                red3_pkg::CFG_HEIGHT:    height_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    red3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .q_push       (f_push),
        .q_px         (f_px),
        .q_col        (f_col),
        .q_ctr        (f_ctr)
    );

    red3_fifo #(
        .DW    (DW),
        .DEPTH (red3_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   ({f_ctr, f_px, f_col}),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {b_ctr, b_px, b_col} = q_dout;

    red3_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .edge_threshold (threshold_reg),
        .q_empty        (q_empty),
        .q_px           (b_px),
        .q_col          (b_col),
        .q_ctr          (b_ctr),
        .q_pop          (q_pop),
        .results        (results)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of range_edge_detect_3x3_core: drives pixel requests,
// predicts every edge result in step and checks the result channel field by field
// depends on red3_pkg, red3_ifs and the rtl of the core
module testbench;
    import red3_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int MAX_H        = MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 700;
    localparam int EXTREME_ITEMS = 150;
    localparam int QUIET_TAIL   = 200;
    localparam int MAX_REPORTS  = 200;

    typedef enum int {TEX_NOISE, TEX_GRAIN, TEX_SPECKLE} texture_t;
    typedef enum int {FRAME_FULL, FRAME_CUT, FRAME_OVERRUN, FRAME_SCATTER} frame_kind_t;

    typedef struct {
        logic [PIX_W-1:0]   edge_pixel;
        logic               center_valid;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic               frame_end;
    } edge_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    red3_pix_if pix ();
    red3_res_if res ();

    range_edge_detect_3x3_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix),
        .results   (res),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [PIX_W-1:0] upper_row [MAX_W];
    logic [PIX_W-1:0] middle_row [MAX_W];
    logic [PIX_W-1:0] window [9];
    int unsigned      row_ctr;
    int unsigned      col_ctr;
    int unsigned      threshold_reg;
    int unsigned      width_reg;
    int unsigned      height_reg;

    edge_result_t     edge_expected [$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      pixels_sent;
    int unsigned      cycle_count;
    int unsigned      gap_pct;
    int unsigned      stall_pct;
    int unsigned      hold_cycles;
    logic             quiet;
    logic             restart_due;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, edge_expected.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned hi);
        if (value < 3)
            return 3;
        if (value > hi)
            return hi;
        return value;
    endfunction

    task automatic reset_model();
        for (int k = 0; k < MAX_W; k++)
        begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end
        for (int k = 0; k < 9; k++)
            window[k] = '0;
        row_ctr       = 0;
        col_ctr       = 0;
        threshold_reg = THRESHOLD_RST;
        width_reg     = WIDTH_RST;
        height_reg    = HEIGHT_RST;
    endtask

    // advances the window by one pixel and returns the edge result it causes
    function automatic edge_result_t predict_edge(input logic [PIX_W-1:0] px, input logic fs);
        int unsigned  w;
        int unsigned  h;
        int unsigned  row;
        int unsigned  col;
        int unsigned  spread;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] lo;
        edge_result_t r;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        if (fs)
        begin
            row_ctr = 0;
            col_ctr = 0;
        end
        if (col_ctr >= w)
        begin
            col_ctr = 0;
            row_ctr++;
        end
        if (row_ctr >= h)
            row_ctr = 0;
        row = row_ctr;
        col = col_ctr;

        up  = upper_row[col];
        mid = middle_row[col];
        upper_row[col]  = mid;
        middle_row[col] = px;

        for (int k = 0; k < 3; k++)
        begin
            window[k*3]     = window[k*3 + 1];
            window[k*3 + 1] = window[k*3 + 2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = px;

        hi = window[0];
        lo = window[0];
        for (int k = 1; k < 9; k++)
        begin
            if (window[k] > hi)
                hi = window[k];
            if (window[k] < lo)
                lo = window[k];
        end
        spread = int'(hi) - int'(lo);

        r.center_valid = (row >= 2) && (col >= 2);
        r.edge_pixel   = (r.center_valid && spread > threshold_reg) ? EDGE_ON : EDGE_OFF;
        r.center_row   = r.center_valid ? COORD_W'(row - 1) : '0;
        r.center_col   = r.center_valid ? COORD_W'(col - 1) : '0;
        r.frame_end    = (row == h - 1) && (col == w - 1);

        col_ctr = col + 1;
        if (col_ctr >= w)
        begin
            col_ctr = 0;
            row_ctr = row + 1;
            if (row_ctr >= h)
                row_ctr = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d %s: got %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    // result monitor
    always @(posedge clk)
    begin
        edge_result_t want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            if (edge_expected.size() == 0)
                report_mismatch("result with no request pending", 0, 0);
            else
            begin
                want = edge_expected.pop_front();
                if (res.edge_pixel !== want.edge_pixel)
                    report_mismatch("edge_pixel", res.edge_pixel, want.edge_pixel);
                if (res.center_valid !== want.center_valid)
                    report_mismatch("center_valid", res.center_valid, want.center_valid);
                if (res.center_row !== want.center_row)
                    report_mismatch("center_row", res.center_row, want.center_row);
                if (res.center_col !== want.center_col)
                    report_mismatch("center_col", res.center_col, want.center_col);
                if (res.frame_end !== want.frame_end)
                    report_mismatch("frame_end", res.frame_end, want.frame_end);
            end
            results_seen++;
        end
    end

    // result side: random stall bursts, plus a long hold-off on demand
    initial
    begin
        int stall;
        stall = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                res.ready <= 1'b0;
            end
            else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall = $urandom_range(1, 5) - 1;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        logic fs_now;
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        // a wider row would read columns this frame never wrote, so start over
        fs_now = fs | restart_due;
        restart_due = 1'b0;
        pix.valid       <= 1'b1;
        pix.pixel_in    <= px;
        pix.frame_start <= fs_now;
        @(posedge clk);
        while (pix.ready !== 1'b1)
            @(posedge clk);
        edge_expected.push_back(predict_edge(px, fs_now));
        pixels_sent++;
    endtask

    task automatic wait_idle();
        pix.valid <= 1'b0;
        while (edge_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD: threshold_reg = value[PIX_W-1:0];
            CFG_WIDTH:
            begin
                if (clamp_dim(value, MAX_W) > clamp_dim(width_reg, MAX_W))
                    restart_due = 1'b1;
                width_reg = value;
            end
            CFG_HEIGHT:    height_reg = value;
            default:       ;
        endcase
    endtask

    function automatic logic [PIX_W-1:0] texture_pixel(input texture_t tex,
                                                       input logic [PIX_W-1:0] base);
        case (tex)
            TEX_NOISE: return PIX_W'($urandom_range(0, 255));
            TEX_GRAIN: return base + PIX_W'($urandom_range(0, 47));
            default:   return ($urandom_range(0, 7) == 0) ? ~base : base;
        endcase
    endfunction

    // range equal to the threshold is no edge, one above it is
    task automatic test_threshold_boundary();
        logic [PIX_W-1:0] px;
        write_reg(CFG_THRESHOLD, 12'd32);
        write_reg(CFG_WIDTH, 12'd3);
        write_reg(CFG_HEIGHT, 12'd4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 3; c++)
            begin
                px = 8'd100;
                if (c == 2 && r == 2)
                    px = 8'd132;
                if (c == 2 && r == 3)
                    px = 8'd133;
                send_pixel(px, r == 0 && c == 0);
            end
        // running past the last pixel without frame_start starts a new frame
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        wait_idle();
        write_reg(CFG_THRESHOLD, 12'd254);
        write_reg(CFG_HEIGHT, 12'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel(((r + c) % 2 == 1) ? 8'd255 : 8'd0, r == 0 && c == 0);
    endtask

    // out of range sizes are clamped: part of a very wide row, then part of a tall frame
    task automatic test_size_extremes();
        wait_idle();
        write_reg(CFG_THRESHOLD, 12'd0);
        write_reg(CFG_WIDTH, 12'd4095);
        write_reg(CFG_HEIGHT, 12'd0);
        for (int k = 0; k < EXTREME_ITEMS; k++)
            send_pixel(($urandom_range(0, 40) == 0) ? PIX_W'($urandom_range(0, 255)) : 8'd77,
                       k == 0);
        wait_idle();
        write_reg(CFG_THRESHOLD, 12'd255);
        write_reg(CFG_WIDTH, 12'd2);
        write_reg(CFG_HEIGHT, 12'd2048);
        for (int k = 0; k < EXTREME_ITEMS; k++)
            send_pixel(PIX_W'($urandom_range(0, 255)), k == 0);
    endtask

    // shrinking a size mid-frame wraps the counters early
    task automatic test_shrink_mid_frame();
        wait_idle();
        write_reg(CFG_THRESHOLD, 12'd40);
        write_reg(CFG_WIDTH, 12'd8);
        write_reg(CFG_HEIGHT, 12'd6);
        for (int k = 0; k < 30; k++)
            send_pixel(texture_pixel(TEX_GRAIN, 8'd60), k == 0);
        wait_idle();
        write_reg(CFG_WIDTH, 12'd5);
        for (int k = 0; k < 12; k++)
            send_pixel(texture_pixel(TEX_SPECKLE, 8'd30), 1'b0);
        wait_idle();
        write_reg(CFG_HEIGHT, 12'd3);
        for (int k = 0; k < 20; k++)
            send_pixel(texture_pixel(TEX_NOISE, 8'd0), 1'b0);
    endtask

    // results held back long enough that the core must stall its input
    task automatic test_output_stall();
        wait_idle();
        write_reg(CFG_THRESHOLD, 12'd20);
        write_reg(CFG_WIDTH, 12'd6);
        write_reg(CFG_HEIGHT, 12'd5);
        gap_pct = 0;
        hold_cycles = 150;
        for (int k = 0; k < 60; k++)
            send_pixel(texture_pixel(TEX_GRAIN, 8'd120), k == 0);
        gap_pct = 20;
    endtask

    task automatic test_random_frames();
        int unsigned      first;
        int unsigned      n;
        int unsigned      w;
        int unsigned      sel;
        frame_kind_t      kind;
        texture_t         tex;
        logic [PIX_W-1:0] base;
        first = pixels_sent;
        while (pixels_sent - first < RANDOM_ITEMS)
        begin
            if (pixels_sent - first >= RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            wait_idle();
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_THRESHOLD, CFG_W'($urandom_range(0, 4095)));
                1:       write_reg(CFG_THRESHOLD, $urandom_range(0, 1) ? 12'd255 : 12'd0);
                default: write_reg(CFG_THRESHOLD, CFG_W'($urandom_range(8, 80)));
            endcase
            write_reg(CFG_WIDTH, ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                                             : CFG_W'($urandom_range(3, 14)));
            write_reg(CFG_HEIGHT, ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                                              : CFG_W'($urandom_range(3, 9)));
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 25;
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            repeat ($urandom_range(1, 3))
            begin
                w    = clamp_dim(width_reg, MAX_W);
                n    = w * clamp_dim(height_reg, MAX_H);
                sel  = $urandom_range(0, 9);
                kind = (sel < 7) ? FRAME_FULL : frame_kind_t'(sel - 6);
                tex  = texture_t'($urandom_range(0, 2));
                base = PIX_W'($urandom_range(0, 255));
                if (kind == FRAME_CUT)
                    n = $urandom_range(1, n - 1);
                if (kind == FRAME_OVERRUN)
                    n = n + $urandom_range(1, 2 * w);
                for (int k = 0; k < n; k++)
                    send_pixel(texture_pixel(tex, base),
                               k == 0 || (kind == FRAME_SCATTER && $urandom_range(0, 19) == 0));
            end
        end
    endtask

    initial
    begin
        pix.valid       <= 1'b0;
        pix.pixel_in    <= '0;
        pix.frame_start <= 1'b0;
        cfg_wen         <= 1'b0;
        cfg_index       <= CFG_THRESHOLD;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        mismatches   = 0;
        results_seen = 0;
        pixels_sent  = 0;
        cycle_count  = 0;
        gap_pct      = 20;
        stall_pct    = 20;
        hold_cycles  = 0;
        quiet        = 1'b0;
        restart_due  = 1'b0;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_threshold_boundary();
        test_size_extremes();
        test_shrink_mid_frame();
        test_output_stall();
        test_random_frames();

        pix.valid <= 1'b0;
        while (edge_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
